### rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and codes of the array linked list manager: request kinds,
// status codes and the control groups passed between its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package alm_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_TRAVERSE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  // node data memory access
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // result control group
  typedef struct packed {
    status_e status;
    logic    last;
  } res_ctl_t;

endpackage

`default_nettype wire

### rtl/alm_store.sv
// ----------------------------------------------------------------------------
// alm_store
// Node data memory: code and grade word of every pool node, one write or
// one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_store #(
  parameter int POOL_NODES = 32
) (
  input  wire                               clk_i,
  input  alm_pkg::mem_ctl_t                 ctl_i,
  input  wire  [$clog2(POOL_NODES)-1:0]     addr_i,
  input  wire  signed [31:0]                wcode_i,
  input  wire  [31:0]                       wgrade_i,
  output logic signed [31:0]                rcode_o,
  output logic [31:0]                       rgrade_o
);
  import alm_pkg::*;

  logic [63:0] mem [POOL_NODES];
  logic [63:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= {wgrade_i, wcode_i};
    end
    if (ctl_i.re) begin
      rd_q <= mem[addr_i];
    end
  end

  assign rcode_o  = signed'(rd_q[31:0]);
  assign rgrade_o = rd_q[63:32];

endmodule

`default_nettype wire

### rtl/alm_out_reg.sv
// ----------------------------------------------------------------------------
// alm_out_reg
// Output register of the result stream: holds one result item until the
// receiver takes it and packs the fields onto the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_out_reg #(
  parameter int POOL_NODES = 32,
  localparam int IDX_W    = $clog2(POOL_NODES + 1),
  localparam int OUT_W    = 2 * IDX_W + 64,
  localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      load_i,
  input  alm_pkg::res_ctl_t        ctl_i,
  input  wire  [IDX_W-1:0]         node_i,
  input  wire  signed [31:0]       code_i,
  input  wire  [31:0]              grade_i,
  input  wire  [IDX_W-1:0]         next_i,
  output logic                     space_o,
  output logic                     m_axis_tvalid_o,
  input  wire                      m_axis_tready_i,
  // node_index, node_code, node_grade, next_index, zero fill
  output logic [TDATA_W-1:0]       m_axis_tdata_o,
  // status
  output logic [1:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);
  import alm_pkg::*;

  logic              valid_q;
  res_ctl_t          ctl_q;
  logic [IDX_W-1:0]  node_q;
  logic [31:0]       code_q;
  logic [31:0]       grade_q;
  logic [IDX_W-1:0]  next_q;

  assign space_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_q   <= ctl_i;
      node_q  <= node_i;
      code_q  <= code_i;
      grade_q <= grade_i;
      next_q  <= next_i;
    end
  end

  always_comb begin
    m_axis_tdata_o            = '0;
    m_axis_tdata_o[OUT_W-1:0] = {next_q, grade_q, code_q, node_q};
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = ctl_q.status;
  assign m_axis_tlast_o  = ctl_q.last;

endmodule

`default_nettype wire

### rtl/alm_ctrl.sv
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer of the list manager: owns the link memory, the list and free
// heads, and steps each request through read-modify-write cycles on it.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_ctrl #(
  parameter int POOL_NODES = 32,
  localparam int IDX_W    = $clog2(POOL_NODES + 1),
  localparam int AW       = $clog2(POOL_NODES)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  alm_pkg::req_e            req_i,
  input  wire  [IDX_W-1:0]         pred_i,
  output alm_pkg::mem_ctl_t        st_ctl_o,
  output logic [AW-1:0]            st_addr_o,
  input  wire  signed [31:0]       st_code_i,
  input  wire  [31:0]              st_grade_i,
  input  wire                      out_space_i,
  output logic                     out_load_o,
  output alm_pkg::res_ctl_t        out_ctl_o,
  output logic [IDX_W-1:0]         out_node_o,
  output logic signed [31:0]       out_code_o,
  output logic [31:0]              out_grade_o,
  output logic [IDX_W-1:0]         out_next_o
);
  import alm_pkg::*;

  localparam logic [IDX_W-1:0] NIL  = IDX_W'(POOL_NODES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_NODES - 1);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_DEL_A,
    S_DEL_B,
    S_DEL_C,
    S_TRV,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  list_head_q, list_head_d;
  logic [IDX_W-1:0]  free_head_q, free_head_d;
  logic [IDX_W-1:0]  pred_q, pred_d;
  logic [IDX_W-1:0]  node_q, node_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  status_e           res_st_q, res_st_d;
  logic [IDX_W-1:0]  res_node_q, res_node_d;
  logic [IDX_W-1:0]  res_next_q, res_next_d;

  // link memory
  logic [IDX_W-1:0]  link_mem [POOL_NODES];
  logic [IDX_W-1:0]  link_rd_q;
  logic              lk_we, lk_re;
  logic [AW-1:0]     lk_waddr, lk_raddr;
  logic [IDX_W-1:0]  lk_wdata;
  logic              trv_fin;

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (lk_re) begin
      link_rd_q <= link_mem[lk_raddr];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign trv_fin    = (link_rd_q >= NIL) || (cnt_q == LAST);

  always_comb begin
    state_d     = state_q;
    list_head_d = list_head_q;
    free_head_d = free_head_q;
    pred_d      = pred_q;
    node_d      = node_q;
    cnt_d       = cnt_q;
    res_st_d    = res_st_q;
    res_node_d  = res_node_q;
    res_next_d  = res_next_q;
    lk_we       = 1'b0;
    lk_waddr    = '0;
    lk_wdata    = '0;
    lk_re       = 1'b0;
    lk_raddr    = '0;
    st_ctl_o    = '0;
    st_addr_o   = '0;
    out_load_o  = 1'b0;
    out_ctl_o   = '{status: ST_OK, last: 1'b0};
    out_node_o  = '0;
    out_code_o  = '0;
    out_grade_o = '0;
    out_next_o  = '0;

    case (state_q)
      S_CLR: begin
        lk_we    = 1'b1;
        lk_waddr = cnt_q[AW-1:0];
        lk_wdata = cnt_q + 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          pred_d     = pred_i;
          res_node_d = NIL;
          res_next_d = NIL;
          case (req_i)
            REQ_INSERT: begin
              if (free_head_q >= NIL) begin
                res_st_d = ST_FULL;
                state_d  = S_RESP;
              end else if (pred_i > NIL) begin
                res_st_d = ST_BAD;
                state_d  = S_RESP;
              end else begin
                node_d      = free_head_q;
                lk_re       = 1'b1;
                lk_raddr    = free_head_q[AW-1:0];
                st_ctl_o.we = 1'b1;
                st_addr_o   = free_head_q[AW-1:0];
                state_d     = S_INS_A;
              end
            end
            REQ_DELETE: begin
              if (list_head_q >= NIL) begin
                res_st_d = ST_EMPTY;
                state_d  = S_RESP;
              end else if (pred_i > NIL) begin
                res_st_d = ST_BAD;
                state_d  = S_RESP;
              end else if (pred_i == NIL) begin
                node_d   = list_head_q;
                lk_re    = 1'b1;
                lk_raddr = list_head_q[AW-1:0];
                state_d  = S_DEL_B;
              end else begin
                lk_re    = 1'b1;
                lk_raddr = pred_i[AW-1:0];
                state_d  = S_DEL_A;
              end
            end
            REQ_TRAVERSE: begin
              if (list_head_q >= NIL) begin
                res_st_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                node_d      = list_head_q;
                cnt_d       = '0;
                lk_re       = 1'b1;
                lk_raddr    = list_head_q[AW-1:0];
                st_ctl_o.re = 1'b1;
                st_addr_o   = list_head_q[AW-1:0];
                state_d     = S_TRV;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_INS_A: begin
        free_head_d = link_rd_q;
        res_st_d    = ST_OK;
        res_node_d  = node_q;
        if (pred_q == NIL) begin
          lk_we       = 1'b1;
          lk_waddr    = node_q[AW-1:0];
          lk_wdata    = list_head_q;
          res_next_d  = list_head_q;
          list_head_d = node_q;
          state_d     = S_RESP;
        end else begin
          lk_re    = 1'b1;
          lk_raddr = pred_q[AW-1:0];
          state_d  = S_INS_B;
        end
      end

      S_INS_B: begin
        lk_we      = 1'b1;
        lk_waddr   = node_q[AW-1:0];
        lk_wdata   = link_rd_q;
        res_next_d = (pred_q == node_q) ? node_q : link_rd_q;
        state_d    = S_INS_C;
      end

      S_INS_C: begin
        lk_we    = 1'b1;
        lk_waddr = pred_q[AW-1:0];
        lk_wdata = node_q;
        state_d  = S_RESP;
      end

      S_DEL_A: begin
        if (link_rd_q >= NIL) begin
          res_st_d = ST_BAD;
          state_d  = S_RESP;
        end else begin
          node_d   = link_rd_q;
          lk_re    = 1'b1;
          lk_raddr = link_rd_q[AW-1:0];
          state_d  = S_DEL_B;
        end
      end

      S_DEL_B: begin
        if (pred_q == NIL) begin
          list_head_d = link_rd_q;
          lk_we       = 1'b1;
          lk_waddr    = node_q[AW-1:0];
          lk_wdata    = free_head_q;
          free_head_d = node_q;
          res_st_d    = ST_OK;
          res_node_d  = node_q;
          res_next_d  = free_head_q;
          state_d     = S_RESP;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = pred_q[AW-1:0];
          lk_wdata = link_rd_q;
          state_d  = S_DEL_C;
        end
      end

      S_DEL_C: begin
        lk_we       = 1'b1;
        lk_waddr    = node_q[AW-1:0];
        lk_wdata    = free_head_q;
        free_head_d = node_q;
        res_st_d    = ST_OK;
        res_node_d  = node_q;
        res_next_d  = free_head_q;
        state_d     = S_RESP;
      end

      S_TRV: begin
        if (out_space_i) begin
          out_load_o  = 1'b1;
          out_ctl_o   = '{status: ST_OK, last: trv_fin};
          out_node_o  = node_q;
          out_code_o  = st_code_i;
          out_grade_o = st_grade_i;
          out_next_o  = link_rd_q;
          if (trv_fin) begin
            state_d = S_IDLE;
          end else begin
            node_d      = link_rd_q;
            cnt_d       = cnt_q + 1'b1;
            lk_re       = 1'b1;
            lk_raddr    = link_rd_q[AW-1:0];
            st_ctl_o.re = 1'b1;
            st_addr_o   = link_rd_q[AW-1:0];
          end
        end
      end

      S_RESP: begin
        if (out_space_i) begin
          out_load_o = 1'b1;
          out_ctl_o  = '{status: res_st_q, last: 1'b1};
          out_node_o = res_node_q;
          out_next_o = res_next_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      list_head_q <= NIL;
      free_head_q <= '0;
      pred_q      <= '0;
      node_q      <= '0;
      cnt_q       <= '0;
      res_st_q    <= ST_OK;
      res_node_q  <= '0;
      res_next_q  <= '0;
    end else begin
      state_q     <= state_d;
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      pred_q      <= pred_d;
      node_q      <= node_d;
      cnt_q       <= cnt_d;
      res_st_q    <= res_st_d;
      res_node_q  <= res_node_d;
      res_next_q  <= res_next_d;
    end
  end

endmodule

`default_nettype wire

### rtl/array_linked_list_manager_unit.sv
// ----------------------------------------------------------------------------
// array_linked_list_manager_unit
// Singly linked list kept in a fixed pool of POOL_NODES nodes, with a free
// list threaded through the same link memory.
//
// Requests come in on the slave stream: tuser is the request kind (insert,
// delete after predecessor, traverse), tdata carries the predecessor index
// (POOL_NODES means the list head), the code and the grade word. Results
// leave on the master stream: tuser is the status, tdata holds the node
// index, code, grade and link, tlast marks the final result of a request.
//
// One request is handled at a time; s_axis_tready_o is high only while the
// sequencer is idle. Insert and delete step through states to their result,
// each step at most one access of the link memory. Traverse reads the list
// head on the request and then gives one node per cycle while the output
// register has space, paced by the link memory read.
// After reset the link memory is initialized in a pass over all POOL_NODES
// entries during which no request is taken. A stalled receiver holds the result in
// the output register, and the sequencer waits for it to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_manager_unit #(
  parameter int POOL_NODES = 32,
  localparam int IDX_W      = $clog2(POOL_NODES + 1),
  localparam int AW         = $clog2(POOL_NODES),
  localparam int IN_TDATA_W = ((IDX_W + 64 + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * IDX_W + 64 + 7) / 8) * 8
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // pred_index, item_code, item_grade, zero fill
  input  wire  [IN_TDATA_W-1:0]    s_axis_tdata_i,
  // req_type
  input  wire  [1:0]               s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire                      m_axis_tready_i,
  // node_index, node_code, node_grade, next_index, zero fill
  output logic [OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic [1:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);
  import alm_pkg::*;

  logic [IDX_W-1:0]   pred;
  logic signed [31:0] item_code;
  logic [31:0]        item_grade;
  mem_ctl_t           st_ctl;
  logic [AW-1:0]      st_addr;
  logic signed [31:0] st_code;
  logic [31:0]        st_grade;
  logic               out_space;
  logic               out_load;
  res_ctl_t           out_ctl;
  logic [IDX_W-1:0]   out_node;
  logic signed [31:0] out_code;
  logic [31:0]        out_grade;
  logic [IDX_W-1:0]   out_next;

  assign pred       = s_axis_tdata_i[IDX_W-1:0];
  assign item_code  = signed'(s_axis_tdata_i[IDX_W+31:IDX_W]);
  assign item_grade = s_axis_tdata_i[IDX_W+63:IDX_W+32];

  alm_ctrl #(
    .POOL_NODES(POOL_NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_i       (req_e'(s_axis_tuser_i)),
    .pred_i      (pred),
    .st_ctl_o    (st_ctl),
    .st_addr_o   (st_addr),
    .st_code_i   (st_code),
    .st_grade_i  (st_grade),
    .out_space_i (out_space),
    .out_load_o  (out_load),
    .out_ctl_o   (out_ctl),
    .out_node_o  (out_node),
    .out_code_o  (out_code),
    .out_grade_o (out_grade),
    .out_next_o  (out_next)
  );

  alm_store #(
    .POOL_NODES(POOL_NODES)
  ) u_store (
    .clk_i    (clk_i),
    .ctl_i    (st_ctl),
    .addr_i   (st_addr),
    .wcode_i  (item_code),
    .wgrade_i (item_grade),
    .rcode_o  (st_code),
    .rgrade_o (st_grade)
  );

  alm_out_reg #(
    .POOL_NODES(POOL_NODES)
  ) u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_load),
    .ctl_i           (out_ctl),
    .node_i          (out_node),
    .code_i          (out_code),
    .grade_i         (out_grade),
    .next_i          (out_next),
    .space_o         (out_space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

### tb/array_linked_list_manager_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager_unit_tb
// Checks the list manager against its own model of the node pool. The model
// tracks the list chain, the free chain and the stored node data, and predicts
// each result of insert, delete and traverse. A short directed part covers
// empty and bad index cases and predecessors off the list. Random requests
// then fill the pool, inserts into the full pool follow, and mixed traffic
// runs. Both streams stall at random.
// ----------------------------------------------------------------------------
module array_linked_list_manager_unit_tb;
  import alm_pkg::*;

  localparam int         NODES = 32;
  localparam logic [5:0] NIL   = 6'd32;

  typedef struct {
    status_e     status;
    logic [5:0]  node;
    logic [31:0] code;
    logic [31:0] grade;
    logic [5:0]  link;
    logic        is_last;
  } node_report_t;

  class list_pool_scoreboard;
    logic [5:0]   link_q [NODES];
    logic [31:0]  code_q [NODES];
    logic [31:0]  grade_q [NODES];
    bit           written_q [NODES];
    logic [5:0]   list_head_q;
    logic [5:0]   free_head_q;
    node_report_t pending_reports[$];
    int           mismatches;

    function new();
      for (int i = 0; i < NODES; i++) begin
        link_q[i] = 6'(i + 1);
        written_q[i] = 1'b0;
      end
      list_head_q = NIL;
      free_head_q = 6'd0;
      mismatches = 0;
    endfunction

    function void queue_report(status_e st, logic [5:0] node, logic [31:0] code,
                               logic [31:0] grade, logic [5:0] link, logic fin);
      node_report_t r;
      r.status = st;
      r.node = node;
      r.code = code;
      r.grade = grade;
      r.link = link;
      r.is_last = fin;
      pending_reports.push_back(r);
    endfunction

    // the request was accepted: update the pool and queue its results
    function void apply_request(logic [1:0] req, logic [5:0] pred, logic [31:0] code,
                                logic [31:0] grade);
      logic [5:0] n;
      logic [5:0] cur;
      int k;
      case (req)
        REQ_INSERT: begin
          if (free_head_q >= NIL) begin
            queue_report(ST_FULL, NIL, '0, '0, NIL, 1'b1);
          end else if (pred > NIL) begin
            queue_report(ST_BAD, NIL, '0, '0, NIL, 1'b1);
          end else begin
            n = free_head_q;
            free_head_q = link_q[n];
            code_q[n] = code;
            grade_q[n] = grade;
            written_q[n] = 1'b1;
            if (pred == NIL) begin
              link_q[n] = list_head_q;
              list_head_q = n;
            end else begin
              link_q[n] = link_q[pred];
              link_q[pred] = n;
            end
            queue_report(ST_OK, n, '0, '0, link_q[n], 1'b1);
          end
        end
        REQ_DELETE: begin
          if (list_head_q >= NIL) begin
            queue_report(ST_EMPTY, NIL, '0, '0, NIL, 1'b1);
          end else if (pred > NIL || (pred < NIL && link_q[pred] >= NIL)) begin
            queue_report(ST_BAD, NIL, '0, '0, NIL, 1'b1);
          end else begin
            if (pred == NIL) begin
              n = list_head_q;
              list_head_q = link_q[n];
            end else begin
              n = link_q[pred];
              link_q[pred] = link_q[n];
            end
            link_q[n] = free_head_q;
            free_head_q = n;
            queue_report(ST_OK, n, '0, '0, link_q[n], 1'b1);
          end
        end
        REQ_TRAVERSE: begin
          cur = list_head_q;
          if (cur >= NIL) begin
            queue_report(ST_EMPTY, NIL, '0, '0, NIL, 1'b1);
          end else begin
            for (k = 0; k < NODES && cur < NIL; k++) begin
              n = link_q[cur];
              queue_report(ST_OK, cur, code_q[cur], grade_q[cur], n,
                           (n >= NIL) || (k == NODES - 1));
              cur = n;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // a traverse now would read node data that was never stored
    function bit traverse_reads_blank();
      logic [5:0] cur;
      cur = list_head_q;
      for (int k = 0; k < NODES && cur < NIL; k++) begin
        if (!written_q[cur]) return 1'b1;
        cur = link_q[cur];
      end
      return 1'b0;
    endfunction

    function logic [5:0] random_listed();
      logic [5:0] chain[$];
      logic [5:0] cur;
      cur = list_head_q;
      for (int k = 0; k < NODES && cur < NIL; k++) begin
        chain.push_back(cur);
        cur = link_q[cur];
      end
      if (chain.size() == 0) return NIL;
      return chain[$urandom_range(chain.size() - 1)];
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] seen);
      $display("%0t: %s expected %0h got %0h", $time, field, want, seen);
      mismatches++;
    endfunction

    function void compare_report(node_report_t got);
      node_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: result expected none got status %0d node %0d", $time,
                 got.status, got.node);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.node !== want.node) flag("node_index", want.node, got.node);
      if (got.code !== want.code) flag("node_code", want.code, got.code);
      if (got.grade !== want.grade) flag("node_grade", want.grade, got.grade);
      if (got.link !== want.link) flag("next_index", want.link, got.link);
      if (got.is_last !== want.is_last) flag("last", want.is_last, got.is_last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [79:0] m_data;
  wire  [1:0]  m_user;
  wire         m_last;
  bit          gaps_on = 1'b1;

  list_pool_scoreboard tracker;

  array_linked_list_manager_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_ready <= !gaps_on || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    node_report_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.status = status_e'(m_user);
      got.node = m_data[5:0];
      got.code = m_data[37:6];
      got.grade = m_data[69:38];
      got.link = m_data[75:70];
      got.is_last = m_last;
      tracker.compare_report(got);
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [5:0] pred,
                              input logic [31:0] code, input logic [31:0] grade);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 35) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= req;
    s_data <= {2'b00, grade, code, pred};
    do @(posedge clk_i); while (!s_ready);
    tracker.apply_request(req, pred, code, grade);
  endtask

  // never walk into nodes whose data was never stored
  task automatic send_traverse();
    if (tracker.traverse_reads_blank()) begin
      send_request(REQ_INSERT, NIL, $urandom, $urandom);
    end else begin
      send_request(REQ_TRAVERSE, 6'($urandom_range(63)), $urandom, $urandom);
    end
  endtask

  initial begin
    logic [1:0] req;
    int roll;
    tracker = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty pool and bad requests
    send_request(REQ_TRAVERSE, NIL, '0, '0);
    send_request(REQ_DELETE, NIL, '0, '0);
    send_request(REQ_DELETE, 6'd63, '0, '0);
    send_request(REQ_INSERT, 6'd33, 32'h1234_5678, 32'h9abc_def0);
    send_request(2'd3, 6'd0, 32'hffff_ffff, 32'hffff_ffff);
    send_request(REQ_INSERT, 6'd63, 32'hdead_beef, 32'h0);
    // build a short list
    send_request(REQ_INSERT, NIL, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_INSERT, NIL, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(REQ_INSERT, 6'd0, 32'hffff_ffff, 32'h5a5a_5a5a);
    send_request(REQ_INSERT, 6'd1, 32'h0000_0000, 32'ha5a5_a5a5);
    send_request(REQ_TRAVERSE, NIL, '0, '0);
    // delete after tail, out of range, after head, at head
    send_request(REQ_DELETE, 6'd2, '0, '0);
    send_request(REQ_DELETE, 6'd40, '0, '0);
    send_request(REQ_DELETE, 6'd1, '0, '0);
    send_request(REQ_DELETE, NIL, '0, '0);
    // predecessors off the list
    send_request(REQ_DELETE, 6'd31, '0, '0);
    send_request(REQ_INSERT, 6'd20, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    send_request(REQ_DELETE, 6'd5, '0, '0);
    send_traverse();
    send_request(REQ_DELETE, 6'd0, '0, '0);
    send_traverse();

    // fill the pool
    for (int k = 0; k < 40 && tracker.free_head_q != NIL; k++) begin
      roll = $urandom_range(99);
      if (roll >= 95) begin
        send_request(REQ_INSERT, 6'($urandom_range(63)), $urandom, $urandom);
      end else begin
        send_request(REQ_INSERT, (roll < 30) ? NIL : tracker.random_listed(),
                     $urandom, $urandom);
      end
    end
    send_traverse();
    send_request(REQ_INSERT, NIL, $urandom, $urandom);
    send_request(REQ_INSERT, 6'd63, $urandom, $urandom);

    // mixed traffic
    for (int k = 0; k < 56; k++) begin
      gaps_on = !(k >= 25 && k < 50);
      roll = $urandom_range(99);
      if (roll < 34) begin
        send_request(REQ_INSERT, ($urandom_range(2) == 0) ? NIL : tracker.random_listed(),
                     $urandom, $urandom);
      end else if (roll < 72) begin
        send_request(REQ_DELETE, ($urandom_range(2) == 0) ? NIL : tracker.random_listed(),
                     $urandom, $urandom);
      end else if (roll < 86) begin
        send_traverse();
      end else begin
        req = 2'($urandom_range(3));
        if (req == REQ_TRAVERSE) send_traverse();
        else send_request(req, 6'($urandom_range(63)), $urandom, $urandom);
      end
    end
    gaps_on = 1'b1;
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (tracker.pending_reports.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
